/* hw/rtl/kda_pkg.sv */
package kda_pkg;

	// Number of key pins handled by the block.
	localparam int unsigned NUM_KEYS = 8;

	// Field widths.
	localparam int unsigned KEY_W   = 8;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned INTEG_W = 8;
	localparam int unsigned FILT_W  = 8;
	localparam int unsigned FIRST_W = 8;
	localparam int unsigned PER_W   = 6;
	localparam int unsigned CFG_W   = 8;
	localparam int unsigned IDX_W   = 2;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_FILTER_COUNT  = 2'd0,
		REG_FIRST_REPEAT  = 2'd1,
		REG_REPEAT_PERIOD = 2'd2,
		REG_KEY_ENABLE    = 2'd3
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic [FILT_W-1:0]  FILTER_COUNT_RST  = 8'd4;
	localparam logic [FIRST_W-1:0] FIRST_REPEAT_RST  = 8'd70;
	localparam logic [PER_W-1:0]   REPEAT_PERIOD_RST = 6'd10;
	localparam logic [KEY_W-1:0]   KEY_ENABLE_RST    = 8'd0;

	// Per-key state held in the state memory.
	typedef struct packed {
		logic [INTEG_W-1:0] integ;
		logic [CNT_W-1:0]   cnt;
		logic               pressed;
	} key_state_t;

	// Configuration seen by the update logic.
	typedef struct packed {
		logic [FILT_W-1:0]  filter_count;
		logic [FIRST_W-1:0] first_repeat;
		logic [PER_W-1:0]   repeat_period;
		logic [KEY_W-1:0]   key_enable;
	} cfg_t;

endpackage

/* hw/rtl/keypad_debounce_autorepeat_top.sv */
// Keypad debouncer with auto-repeat.
// Each input word on the s_ channel is one sample tick: bit k of s_tdata is
// the raw level of key k, low meaning pressed. For each tick exactly one
// output word leaves on the m_ channel: key_events in m_tdata[7:0] marks keys
// that were newly pressed or auto-repeat this tick, pressed_keys in
// m_tdata[15:8] gives the debounced pressed state of the enabled keys.
// While the receiver keeps up, one word is accepted per cycle; the per-key
// state sits in a state memory that is read at acceptance and written back
// when stage 1 moves on, with the write forwarded to a read on the same
// edge. The user writes configuration through cfg_we, cfg_index and
// cfg_wdata only while no word is in flight; the block does not enforce
// this. Reset clears all key state to released and loads the default
// register values. If the receiver stalls, the output register and the
// pending stage fill and s_tready drops; nothing is lost or repeated.
module keypad_debounce_autorepeat_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] pin_levels
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,  // [7:0] key_events, [15:8] pressed_keys
	input  logic                           cfg_we,
	input  logic [kda_pkg::IDX_W-1:0]      cfg_index,
	input  logic [kda_pkg::CFG_W-1:0]      cfg_wdata
);

	kda_pkg::cfg_t cfg_q;

	logic                                        s1_valid;
	logic [kda_pkg::KEY_W-1:0]                   levels_s1;
	logic                                        s1_adv;
	logic                                        in_acc;
	kda_pkg::key_state_t [kda_pkg::NUM_KEYS-1:0] cur_state;
	kda_pkg::key_state_t [kda_pkg::NUM_KEYS-1:0] nxt_state;
	logic [kda_pkg::KEY_W-1:0]                   events;
	logic [kda_pkg::KEY_W-1:0]                   pressed;
	logic                                        out_valid_q;
	logic [15:0]                                 out_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_count  <= kda_pkg::FILTER_COUNT_RST;
			cfg_q.first_repeat  <= kda_pkg::FIRST_REPEAT_RST;
			cfg_q.repeat_period <= kda_pkg::REPEAT_PERIOD_RST;
			cfg_q.key_enable    <= kda_pkg::KEY_ENABLE_RST;
		end else if (cfg_we) begin
			case (kda_pkg::cfg_reg_t'(cfg_index))
				kda_pkg::REG_FILTER_COUNT:  cfg_q.filter_count  <= cfg_wdata;
				kda_pkg::REG_FIRST_REPEAT:  cfg_q.first_repeat  <= cfg_wdata;
				kda_pkg::REG_REPEAT_PERIOD: cfg_q.repeat_period <= cfg_wdata[kda_pkg::PER_W-1:0];
				kda_pkg::REG_KEY_ENABLE:    cfg_q.key_enable    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Handshake: stage 1 moves on when the output register is free or draining.
	assign s1_adv   = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || s1_adv;
	assign in_acc   = s_tvalid && s_tready;

	// State memory: read on acceptance, written back when stage 1 moves on.
	kda_state_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.wr_en   (s1_adv),
		.wr_data (nxt_state),
		.rd_data (cur_state)
	);

	// Per-key debounce and repeat logic.
	kda_key_update u_upd (
		.cfg     (cfg_q),
		.levels  (levels_s1),
		.cur     (cur_state),
		.nxt     (nxt_state),
		.events  (events),
		.pressed (pressed)
	);

	// Stage 1 valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			levels_s1 <= s_tdata;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= {pressed, events};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* hw/rtl/kda_state_ram.sv */
module kda_state_ram (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      rd_en,
	input  logic                                      wr_en,
	input  kda_pkg::key_state_t [kda_pkg::NUM_KEYS-1:0] wr_data,
	output kda_pkg::key_state_t [kda_pkg::NUM_KEYS-1:0] rd_data
);

	// One entry per key; all keys are written and read together.
	kda_pkg::key_state_t                         mem [kda_pkg::NUM_KEYS];
	logic                [kda_pkg::NUM_KEYS-1:0] vld_q;
	kda_pkg::key_state_t [kda_pkg::NUM_KEYS-1:0] rd_q;

	// Entries not yet written read as the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q <= '1;
		end
	end

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int k = 0; k < kda_pkg::NUM_KEYS; k++) begin
				mem[k] <= wr_data[k];
			end
		end
	end

	// Registered read with write-through forwarding for a same-edge update.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			for (int k = 0; k < kda_pkg::NUM_KEYS; k++) begin
				if (wr_en) begin
					rd_q[k] <= wr_data[k];
				end else if (vld_q[k]) begin
					rd_q[k] <= mem[k];
				end else begin
					rd_q[k] <= '0;
				end
			end
		end
	end

	assign rd_data = rd_q;

endmodule

/* hw/rtl/kda_key_update.sv */
module kda_key_update (
	input  kda_pkg::cfg_t                              cfg,
	input  logic [kda_pkg::KEY_W-1:0]                  levels,
	input  kda_pkg::key_state_t [kda_pkg::NUM_KEYS-1:0] cur,
	output kda_pkg::key_state_t [kda_pkg::NUM_KEYS-1:0] nxt,
	output logic [kda_pkg::KEY_W-1:0]                  events,
	output logic [kda_pkg::KEY_W-1:0]                  pressed
);

	// Counter value at which the repeat cycle wraps; a 9-bit sum.
	logic [kda_pkg::CNT_W:0] wrap_at;

	assign wrap_at = {1'b0, cfg.first_repeat} + {3'b000, cfg.repeat_period};

	// One independent lane per key.
	always_comb begin
		logic [kda_pkg::INTEG_W-1:0] integ;
		logic [kda_pkg::CNT_W-1:0]   cnt;
		logic                        st;
		events  = '0;
		pressed = '0;
		for (int k = 0; k < kda_pkg::NUM_KEYS; k++) begin
			integ = cur[k].integ;
			cnt   = cur[k].cnt;
			st    = cur[k].pressed;
			if (cfg.key_enable[k]) begin
				// Integrate the pin level toward pressed or released.
				if (!levels[k]) begin
					if (integ < cfg.filter_count) begin
						integ = integ + 1'b1;
						if (integ == cfg.filter_count) begin
							st  = 1'b1;
							cnt = '0;
						end
					end
				end else if (integ != '0) begin
					integ = integ - 1'b1;
					if (integ == '0) begin
						st = 1'b0;
					end
				end
				// Press and auto-repeat events.
				if (st) begin
					if (cnt == '0 || cnt == cfg.first_repeat ||
						{1'b0, cnt} == wrap_at) begin
						events[k] = 1'b1;
					end
					if ({1'b0, cnt} == wrap_at) begin
						cnt = cfg.first_repeat;
					end
					cnt        = cnt + 1'b1;
					pressed[k] = 1'b1;
				end
			end
			nxt[k].integ   = integ;
			nxt[k].cnt     = cnt;
			nxt[k].pressed = st;
		end
	end

endmodule
